### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define TLPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlpc assertion failed");

// next-cycle implication, off during reset
`define TLPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlpc assertion failed");

`endif

### hw/rtl/tlpc_pkg.sv
package tlpc_pkg;

    // raw command codes on the cmd port
    localparam logic [2:0] CMD_WR_LABEL = 3'd0;
    localparam logic [2:0] CMD_WR_ORDER = 3'd1;
    localparam logic [2:0] CMD_QUERY    = 3'd2;
    localparam logic [2:0] CMD_RD_COUNT = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    // fixed port field widths
    localparam int CMD_W   = 3;
    localparam int TREE_FW = 6;
    localparam int POS_FW  = 10;
    localparam int VAL_FW  = 16;
    localparam int OBS_FW  = 11;
    localparam int RDC_FW  = 16;

    // below this span the search scans linearly
    localparam int LIN_LIMIT = 6;

    // command queue depth
    localparam int Q_DEPTH = 2;

    // classified operation
    typedef enum logic [2:0] {
        OP_NOP = 3'd0,
        OP_WRL = 3'd1,
        OP_WRO = 3'd2,
        OP_QRY = 3'd3,
        OP_RDC = 3'd4,
        OP_CLR = 3'd5
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TREE_FW-1:0] tree;
        logic [POS_FW-1:0]  pos;
        logic [VAL_FW-1:0]  val;
    } cmd_t;

    // what the table probe is doing
    typedef enum logic [1:0] {
        PH_BIN  = 2'd0,
        PH_LIN  = 2'd1,
        PH_DOWN = 2'd2,
        PH_UP   = 2'd3
    } phase_t;

endpackage

### hw/rtl/tree_leaf_proximity_counter_core.sv
// Order of work: writes and no-ops finish once dispatched; a counter read
// reads the counter table; clear sweeps every counter; a query halves the
// span, scans linearly below LIN_LIMIT, then walks over matching entries.
// Throughput: one transaction at a time in the back end, set by the chain
// of order-table then label-table reads per probe; a 2-entry queue buffers.
// Reset: asynchronous, active low; then a clearing pass over all counters
// with busy high. Results are single-cycle strobes; the receiver cannot stall.
module tree_leaf_proximity_counter_core #(
    parameter int MAX_OBS    = 1024,
    parameter int MAX_TREES  = 64,
    parameter int LABEL_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tlpc_pkg::OBS_FW-1:0]   cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [tlpc_pkg::CMD_W-1:0]    cmd,
    input  logic [tlpc_pkg::TREE_FW-1:0]  tree_index,
    input  logic [tlpc_pkg::POS_FW-1:0]   position,
    input  logic [tlpc_pkg::VAL_FW-1:0]   item_value,
    output logic                          done,
    output logic [tlpc_pkg::RDC_FW-1:0]   read_count,
    output logic                          match_found,
    output logic [tlpc_pkg::OBS_FW-1:0]   match_count
);
    import tlpc_pkg::*;

    localparam int OBS_W = $clog2(MAX_OBS);
    localparam int IDX_W = OBS_W + 1;

    logic [OBS_FW-1:0] obs_in_use_reg;
    logic [IDX_W-1:0]  n_obs;
    logic              q_full, push, pop, head_valid, init_busy;
    cmd_t              push_data, head_data;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            obs_in_use_reg <= OBS_FW'(1024);
        else if (cfg_we)
            obs_in_use_reg <= cfg_wdata;
    end

    // clamp to the table depth
    assign n_obs = (32'(obs_in_use_reg) > MAX_OBS) ? IDX_W'(MAX_OBS)
                                                   : IDX_W'(obs_in_use_reg);

    tlpc_front #(
        .MAX_OBS   (MAX_OBS),
        .MAX_TREES (MAX_TREES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .tree_index (tree_index),
        .position   (position),
        .item_value (item_value),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data)
    );

    tlpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    tlpc_back #(
        .MAX_OBS    (MAX_OBS),
        .MAX_TREES  (MAX_TREES),
        .LABEL_BITS (LABEL_BITS),
        .COUNT_BITS (COUNT_BITS),
        .OBS_W      (OBS_W),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .n_obs       (n_obs),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .init_busy   (init_busy),
        .done        (done),
        .read_count  (read_count),
        .match_found (match_found),
        .match_count (match_count)
    );

endmodule

### hw/rtl/tlpc_front.sv
module tlpc_front #(
    parameter int MAX_OBS   = 1024,
    parameter int MAX_TREES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tlpc_pkg::CMD_W-1:0]  cmd,
    input  logic [tlpc_pkg::TREE_FW-1:0] tree_index,
    input  logic [tlpc_pkg::POS_FW-1:0] position,
    input  logic [tlpc_pkg::VAL_FW-1:0] item_value,
    input  logic                        q_full,
    input  logic                        init_busy,
    output logic                        busy,
    output logic                        push,
    output tlpc_pkg::cmd_t              push_data
);
    import tlpc_pkg::*;

    logic  valid_reg, valid_next;
    cmd_t  hold_reg, hold_next;
    logic  tree_ok, pos_ok, val_ok, accept;
    op_t   op;

    // range checks
    assign tree_ok = 32'(tree_index) < MAX_TREES;
    assign pos_ok  = 32'(position) < MAX_OBS;
    assign val_ok  = 32'(item_value) < MAX_OBS;

    // classify: anything that has no effect becomes a no-op
    always_comb
    begin
        unique case (cmd)
            CMD_WR_LABEL: op = (tree_ok && pos_ok) ? OP_WRL : OP_NOP;
            CMD_WR_ORDER: op = (tree_ok && pos_ok && val_ok) ? OP_WRO : OP_NOP;
            CMD_QUERY:    op = tree_ok ? OP_QRY : OP_NOP;
            CMD_RD_COUNT: op = pos_ok ? OP_RDC : OP_NOP;
            CMD_CLEAR:    op = OP_CLR;
            default:      op = OP_NOP;
        endcase
    end

    assign push   = valid_reg && !q_full;
    assign busy   = init_busy || (valid_reg && q_full);
    assign accept = start && !busy;

    always_comb
    begin
        valid_next = valid_reg;
        hold_next  = hold_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            hold_next  = '{op: op, tree: tree_index, pos: position, val: item_value};
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign push_data = hold_reg;

endmodule

### hw/rtl/tlpc_queue.sv
module tlpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tlpc_pkg::cmd_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output tlpc_pkg::cmd_t head_data
);
    import tlpc_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    cmd_t               mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign full       = count_reg == (PTR_W+1)'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hw/rtl/tlpc_back.sv
module tlpc_back #(
    parameter int MAX_OBS    = 1024,
    parameter int MAX_TREES  = 64,
    parameter int LABEL_BITS = 16,
    parameter int COUNT_BITS = 16,
    parameter int OBS_W      = $clog2(MAX_OBS),
    parameter int IDX_W      = OBS_W + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [IDX_W-1:0]              n_obs,
    input  logic                          head_valid,
    input  tlpc_pkg::cmd_t                head_data,
    output logic                          pop,
    output logic                          init_busy,
    output logic                          done,
    output logic [tlpc_pkg::RDC_FW-1:0]   read_count,
    output logic                          match_found,
    output logic [tlpc_pkg::OBS_FW-1:0]   match_count
);
    import tlpc_pkg::*;

    localparam int TREE_W    = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int ADDR_W    = TREE_W + OBS_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_RD   = 9'b000000100,
        S_SRCH = 9'b000001000,
        S_ORD  = 9'b000010000,
        S_LAB  = 9'b000100000,
        S_CMP  = 9'b001000000,
        S_BUMP = 9'b010000000,
        S_CLR  = 9'b100000000
    } state_t;

    // tables
    logic [LABEL_BITS-1:0] lab_mem [MEM_DEPTH];
    logic [OBS_W-1:0]      ord_mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem [MAX_OBS];

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [TREE_W-1:0]     tree_reg, tree_next;
    logic [LABEL_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]      top_reg, top_next;
    logic [IDX_W-1:0]      bot_reg, bot_next;
    logic [IDX_W-1:0]      m_reg, m_next;
    logic [IDX_W-1:0]      hit_reg, hit_next;
    logic [OBS_W-1:0]      o_reg, o_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic [OBS_W-1:0]      clr_reg, clr_next;

    logic [OBS_W-1:0]      ord_rd_reg;
    logic [LABEL_BITS-1:0] lab_rd_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;

    logic                  done_reg, done_next;
    logic [RDC_FW-1:0]     rdc_reg, rdc_next;
    logic                  found_reg, found_next;
    logic [OBS_FW-1:0]     mcnt_reg, mcnt_next;

    // memory port controls
    logic                  lab_we, ord_we, cnt_we;
    logic [ADDR_W-1:0]     wr_addr, ord_raddr, lab_raddr;
    logic [OBS_W-1:0]      cnt_waddr, cnt_raddr, o_clamp;
    logic [COUNT_BITS-1:0] cnt_wdata;

    // search helpers
    logic [IDX_W:0]        mid_sum;
    logic [IDX_W-1:0]      span, cnt_now, hit_up;
    logic                  eq, up_ok, clr_last;

    assign mid_sum  = (IDX_W+1)'(top_reg) + (IDX_W+1)'(bot_reg);
    assign span     = bot_reg - top_reg;
    assign eq       = lab_rd_reg == key_reg;
    assign hit_up   = hit_reg + 1'b1;
    assign up_ok    = hit_up < bot_reg;
    assign clr_last = clr_reg == OBS_W'(MAX_OBS - 1);
    assign o_clamp  = (32'(ord_rd_reg) >= MAX_OBS) ? '0 : ord_rd_reg;

    assign wr_addr   = {TREE_W'(head_data.tree), OBS_W'(head_data.pos)};
    assign ord_raddr = {tree_reg, m_reg[OBS_W-1:0]};
    assign lab_raddr = {tree_reg, o_clamp};
    assign cnt_raddr = (state_reg == S_IDLE) ? OBS_W'(head_data.pos) : o_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        tree_next  = tree_reg;
        key_next   = key_reg;
        top_next   = top_reg;
        bot_next   = bot_reg;
        m_next     = m_reg;
        hit_next   = hit_reg;
        o_next     = o_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        rdc_next   = '0;
        found_next = 1'b0;
        mcnt_next  = '0;
        pop        = 1'b0;
        lab_we     = 1'b0;
        ord_we     = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = clr_reg;
        cnt_wdata  = '0;
        cnt_now    = (state_reg == S_BUMP) ? cnt_reg + 1'b1 : cnt_reg;

        unique case (state_reg)
            // clearing pass after reset, no result
            S_INIT:
            begin
                cnt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_last)
                    state_next = S_IDLE;
            end

            // clear command sweep
            S_CLR:
            begin
                cnt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // dispatch the next queued transaction
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    unique case (head_data.op)
                        OP_WRL:
                        begin
                            lab_we    = 1'b1;
                            done_next = 1'b1;
                        end
                        OP_WRO:
                        begin
                            ord_we    = 1'b1;
                            done_next = 1'b1;
                        end
                        OP_RDC:
                            state_next = S_RD;
                        OP_CLR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        OP_QRY:
                        begin
                            tree_next  = TREE_W'(head_data.tree);
                            key_next   = LABEL_BITS'(head_data.val);
                            top_next   = '0;
                            bot_next   = n_obs;
                            cnt_next   = '0;
                            state_next = S_SRCH;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end

            S_RD:
            begin
                done_next  = 1'b1;
                rdc_next   = RDC_FW'(cnt_rd_reg);
                state_next = S_IDLE;
            end

            // pick the next probe: halve or scan
            S_SRCH:
            begin
                if (span < IDX_W'(LIN_LIMIT))
                begin
                    if (top_reg < bot_reg)
                    begin
                        m_next     = top_reg;
                        phase_next = PH_LIN;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    m_next     = mid_sum[IDX_W:1];
                    phase_next = PH_BIN;
                    state_next = S_ORD;
                end
            end

            // order read in flight
            S_ORD:
                state_next = S_LAB;

            // label read in flight
            S_LAB:
            begin
                o_next     = o_clamp;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (eq)
                begin
                    // count this entry, counter read issued now
                    if (phase_reg == PH_BIN || phase_reg == PH_LIN)
                    begin
                        hit_next   = m_reg;
                        phase_next = PH_DOWN;
                    end
                    state_next = S_BUMP;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_BIN:
                        begin
                            if (key_reg > lab_rd_reg)
                                top_next = m_reg;
                            else
                                bot_next = m_reg;
                            state_next = S_SRCH;
                        end
                        PH_LIN:
                        begin
                            if ((m_reg + 1'b1) < bot_reg)
                            begin
                                m_next     = m_reg + 1'b1;
                                state_next = S_ORD;
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        PH_DOWN:
                        begin
                            if (up_ok)
                            begin
                                m_next     = hit_up;
                                phase_next = PH_UP;
                                state_next = S_ORD;
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                found_next = 1'b1;
                                mcnt_next  = OBS_FW'(cnt_now);
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            found_next = 1'b1;
                            mcnt_next  = OBS_FW'(cnt_now);
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // saturating increment, then continue the walk or finish
            S_BUMP:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = o_reg;
                cnt_wdata = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
                cnt_next  = cnt_now;
                if (phase_reg == PH_DOWN && m_reg != '0)
                begin
                    m_next     = m_reg - 1'b1;
                    state_next = S_ORD;
                end
                else if (phase_reg == PH_DOWN && up_ok)
                begin
                    m_next     = hit_up;
                    phase_next = PH_UP;
                    state_next = S_ORD;
                end
                else if (phase_reg == PH_UP && (m_reg + 1'b1) < bot_reg)
                begin
                    m_next     = m_reg + 1'b1;
                    state_next = S_ORD;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    mcnt_next  = OBS_FW'(cnt_now);
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            rdc_reg   <= '0;
            found_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            rdc_reg   <= rdc_next;
            found_reg <= found_next;
            mcnt_reg  <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        tree_reg  <= tree_next;
        key_reg   <= key_next;
        top_reg   <= top_next;
        bot_reg   <= bot_next;
        m_reg     <= m_next;
        hit_reg   <= hit_next;
        o_reg     <= o_next;
        cnt_reg   <= cnt_next;
    end

    // label table
    always_ff @(posedge clk)
    begin
        if (lab_we)
            lab_mem[wr_addr] <= LABEL_BITS'(head_data.val);
        lab_rd_reg <= lab_mem[lab_raddr];
    end

    // order table
    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[wr_addr] <= OBS_W'(head_data.val);
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    // proximity counters
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    assign init_busy   = state_reg == S_INIT;
    assign done        = done_reg;
    assign read_count  = rdc_reg;
    assign match_found = found_reg;
    assign match_count = mcnt_reg;

endmodule

### hw/rtl/tlpc_checker.sv
`include "assert_macros.svh"

module tlpc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          done,
    input logic [tlpc_pkg::RDC_FW-1:0]   read_count,
    input logic                          match_found,
    input logic [tlpc_pkg::OBS_FW-1:0]   match_count
);

    // result fields are quiet between strobes
    `TLPC_ASSERT_IMP(a_idle_zero, clk, rst_n, !done, read_count == '0 && !match_found && match_count == '0)

    // a found query counts at least one entry and returns no counter value
    `TLPC_ASSERT_IMP(a_found_cnt, clk, rst_n, done && match_found, match_count != '0 && read_count == '0)

    // a miss counts nothing
    `TLPC_ASSERT_IMP(a_miss_cnt, clk, rst_n, done && !match_found, match_count == '0)

    // the counter clearing pass holds off transactions after reset
    `TLPC_ASSERT_NXT(a_init_busy, clk, rst_n, $rose(rst_n), busy)

endmodule

bind tree_leaf_proximity_counter_core tlpc_checker u_tlpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .done        (done),
    .read_count  (read_count),
    .match_found (match_found),
    .match_count (match_count)
);
